/* sv/gkpsc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gkpsc_pkg
// Shared constants, command codes and control/status types of the
// gap-keeping PID speed controller.
// ----------------------------------------------------------------------------
package gkpsc_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED = 3'd4;

    localparam logic [16:0] TIME_STEP_RST = 17'd6554;
    localparam logic [21:0] MAX_SPEED_RST = 22'd1092267;

    localparam logic signed [25:0] SAFE_DIST_Q = 26'sd524288;
    localparam logic signed [31:0] K045_Q16    = 32'sd29491;
    localparam logic signed [31:0] K0001_Q32   = 32'sd4294967;
    localparam logic signed [19:0] ACCEL_MIN_Q = -20'sd458752;
    localparam logic signed [19:0] ACCEL_MAX_Q = 20'sd65536;

    localparam logic [2:0] MUL_NONE = 3'd0;
    localparam logic [2:0] MUL_GERR = 3'd1;
    localparam logic [2:0] MUL_SETP = 3'd2;
    localparam logic [2:0] MUL_P    = 3'd3;
    localparam logic [2:0] MUL_I    = 3'd4;
    localparam logic [2:0] MUL_D    = 3'd5;
    localparam logic [2:0] MUL_TS   = 3'd6;

    localparam logic [2:0] UPD_NONE      = 3'd0;
    localparam logic [2:0] UPD_GERR      = 3'd1;
    localparam logic [2:0] UPD_SETP      = 3'd2;
    localparam logic [2:0] UPD_INTEG     = 3'd3;
    localparam logic [2:0] UPD_ACC_FIRST = 3'd4;
    localparam logic [2:0] UPD_ACC_ADD   = 3'd5;
    localparam logic [2:0] UPD_ACC_LAST  = 3'd6;

    typedef struct packed {
        logic       load;
        logic       clr_state;
        logic [2:0] mul_sel;
        logic [2:0] upd_sel;
        logic       out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic is_release;
    } dp_sts_t;

endpackage

/* sv/gkpsc_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gkpsc_meas_if / gkpsc_act_if
// Valid/ready channels for measurement words and actuation words.
// ----------------------------------------------------------------------------
interface gkpsc_meas_if;
    logic               valid;
    logic               ready;
    logic               opcode;
    logic [21:0]        vehicle_speed;
    logic [23:0]        gap_distance;
    logic signed [22:0] front_rel_speed;
    logic [21:0]        curve_speed_limit;
    logic               in_curve;

    modport source (
        output valid, opcode, vehicle_speed, gap_distance, front_rel_speed,
               curve_speed_limit, in_curve,
        input  ready
    );
    modport sink (
        input  valid, opcode, vehicle_speed, gap_distance, front_rel_speed,
               curve_speed_limit, in_curve,
        output ready
    );
endinterface

interface gkpsc_act_if;
    logic               valid;
    logic               ready;
    logic [21:0]        target_speed;
    logic signed [19:0] control_accel;
    logic signed [24:0] gap_error;
    logic               keeping_distance;

    modport source (
        output valid, target_speed, control_accel, gap_error, keeping_distance,
        input  ready
    );
    modport sink (
        input  valid, target_speed, control_accel, gap_error, keeping_distance,
        output ready
    );
endinterface

/* sv/gkpsc_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gkpsc_dp
// Datapath: configuration registers, input latch, shared 32x32 multiplier,
// PID state and the output word register.
// ----------------------------------------------------------------------------
module gkpsc_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [gkpsc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gkpsc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                                opcode,
    input  logic [21:0]                         vehicle_speed,
    input  logic [23:0]                         gap_distance,
    input  logic signed [22:0]                  front_rel_speed,
    input  logic [21:0]                         curve_speed_limit,
    input  logic                                in_curve,
    input  gkpsc_pkg::dp_cmd_t                  ctl,
    output gkpsc_pkg::dp_sts_t                  sts,
    output logic [21:0]                         target_speed,
    output logic signed [19:0]                  control_accel,
    output logic signed [24:0]                  gap_error,
    output logic                                keeping_distance
);

    logic signed [31:0] gain_p_reg, gain_i_reg, gain_d_reg;
    logic [16:0]        time_step_reg;
    logic [21:0]        max_speed_reg;

    logic               op_reg;
    logic [21:0]        v_reg;
    logic [23:0]        gap_reg;
    logic signed [22:0] rel_reg;
    logic [21:0]        curve_reg;
    logic               in_curve_reg;

    logic signed [25:0] gerr_reg;
    logic               keep_reg;
    logic signed [27:0] sp_reg;
    logic signed [28:0] d_reg;
    logic signed [27:0] prev_reg;
    logic signed [31:0] integ_reg;
    logic signed [49:0] acc_sum_reg;
    logic signed [19:0] acc_reg;
    logic signed [63:0] prod_reg;

    logic [21:0]        tgt_reg;
    logic signed [19:0] out_acc_reg;
    logic signed [24:0] out_gerr_reg;
    logic               out_keep_reg;

    logic [23:0]        v3;
    logic signed [25:0] gerr_next;
    logic signed [24:0] rel3;
    logic signed [24:0] rel_q;
    logic signed [27:0] sp_next;
    logic signed [27:0] prev_eff;
    logic signed [28:0] d_next;
    logic signed [32:0] integ_sum;
    logic signed [31:0] integ_next;
    logic signed [49:0] term;
    logic signed [49:0] acc_full;
    logic signed [19:0] acc_next;
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] prod_next;
    logic signed [24:0] spd, spd_cap;
    logic [21:0]        spd_next;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg    <= '0;
            gain_i_reg    <= '0;
            gain_d_reg    <= '0;
            time_step_reg <= gkpsc_pkg::TIME_STEP_RST;
            max_speed_reg <= gkpsc_pkg::MAX_SPEED_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                gkpsc_pkg::REG_GAIN_P:    gain_p_reg    <= $signed(cfg_wdata);
                gkpsc_pkg::REG_GAIN_I:    gain_i_reg    <= $signed(cfg_wdata);
                gkpsc_pkg::REG_GAIN_D:    gain_d_reg    <= $signed(cfg_wdata);
                gkpsc_pkg::REG_TIME_STEP: time_step_reg <= cfg_wdata[16:0];
                gkpsc_pkg::REG_MAX_SPEED: max_speed_reg <= cfg_wdata[21:0];
                default:                  ;
            endcase
        end
    end

    // gap error and setpoint
    assign v3        = {2'b00, v_reg} + {1'b0, v_reg, 1'b0};
    assign gerr_next = $signed({2'b00, gap_reg}) - gkpsc_pkg::SAFE_DIST_Q
                     - $signed({3'b000, v3[23:1]});
    assign rel3      = $signed({{2{rel_reg[22]}}, rel_reg})
                     + $signed({rel_reg[22], rel_reg, 1'b0});
    assign rel_q     = rel3 >>> 2;
    assign sp_next   = $signed({{3{rel_q[24]}}, rel_q})
                     + $signed({{2{prod_reg[41]}}, prod_reg[41:16]});
    assign prev_eff  = (prev_reg == '0) ? sp_next : prev_reg;
    assign d_next    = $signed({sp_next[27], sp_next}) - $signed({prev_eff[27], prev_eff});

    // integral with saturation
    assign integ_sum = $signed({integ_reg[31], integ_reg})
                     + $signed({prod_reg[63], prod_reg[63:32]});
    always_comb
    begin
        if (integ_sum[32] != integ_sum[31])
            integ_next = integ_sum[32] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
        else
            integ_next = integ_sum[31:0];
    end

    // PID sum and clamp
    assign term     = $signed({{2{prod_reg[63]}}, prod_reg[63:16]});
    assign acc_full = acc_sum_reg + term;
    always_comb
    begin
        if (acc_full < $signed({{30{gkpsc_pkg::ACCEL_MIN_Q[19]}}, gkpsc_pkg::ACCEL_MIN_Q}))
            acc_next = gkpsc_pkg::ACCEL_MIN_Q;
        else if (acc_full > $signed({30'd0, gkpsc_pkg::ACCEL_MAX_Q}))
            acc_next = gkpsc_pkg::ACCEL_MAX_Q;
        else
            acc_next = acc_full[19:0];
    end

    // shared multiplier operand select
    always_comb
    begin
        case (ctl.mul_sel)
            gkpsc_pkg::MUL_GERR:
            begin
                mul_a = $signed({{6{gerr_reg[25]}}, gerr_reg});
                mul_b = gkpsc_pkg::K045_Q16;
            end
            gkpsc_pkg::MUL_SETP:
            begin
                mul_a = $signed({{4{sp_reg[27]}}, sp_reg});
                mul_b = gkpsc_pkg::K0001_Q32;
            end
            gkpsc_pkg::MUL_P:
            begin
                mul_a = gain_p_reg;
                mul_b = $signed({{4{sp_reg[27]}}, sp_reg});
            end
            gkpsc_pkg::MUL_I:
            begin
                mul_a = gain_i_reg;
                mul_b = integ_reg;
            end
            gkpsc_pkg::MUL_D:
            begin
                mul_a = gain_d_reg;
                mul_b = $signed({{3{d_reg[28]}}, d_reg});
            end
            gkpsc_pkg::MUL_TS:
            begin
                mul_a = $signed({{12{acc_reg[19]}}, acc_reg});
                mul_b = $signed({15'd0, time_step_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // commanded speed
    assign spd = $signed({3'b000, v_reg}) + $signed(prod_reg[40:16]);
    always_comb
    begin
        if (in_curve_reg && ($signed({3'b000, curve_reg}) < spd))
            spd_cap = $signed({3'b000, curve_reg});
        else
            spd_cap = spd;
        if (spd_cap < 0)
            spd_next = '0;
        else if (spd_cap > $signed({3'b000, max_speed_reg}))
            spd_next = max_speed_reg;
        else
            spd_next = spd_cap[21:0];
    end

    // PID state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg <= '0;
            prev_reg  <= '0;
        end
        else if (ctl.clr_state)
        begin
            integ_reg <= '0;
            prev_reg  <= '0;
        end
        else
        begin
            if (ctl.upd_sel == gkpsc_pkg::UPD_SETP)
                prev_reg <= sp_next;
            if (ctl.upd_sel == gkpsc_pkg::UPD_INTEG)
                integ_reg <= integ_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            op_reg       <= opcode;
            v_reg        <= vehicle_speed;
            gap_reg      <= gap_distance;
            rel_reg      <= front_rel_speed;
            curve_reg    <= curve_speed_limit;
            in_curve_reg <= in_curve;
        end
        if (ctl.mul_sel != gkpsc_pkg::MUL_NONE)
            prod_reg <= prod_next;
        case (ctl.upd_sel)
            gkpsc_pkg::UPD_GERR:
            begin
                gerr_reg <= gerr_next;
                keep_reg <= rel_reg[22] && gerr_next[25];
            end
            gkpsc_pkg::UPD_SETP:
            begin
                sp_reg <= sp_next;
                d_reg  <= d_next;
            end
            gkpsc_pkg::UPD_ACC_FIRST: acc_sum_reg <= term;
            gkpsc_pkg::UPD_ACC_ADD:   acc_sum_reg <= acc_full;
            gkpsc_pkg::UPD_ACC_LAST:  acc_reg     <= acc_next;
            default:                  ;
        endcase
        if (ctl.out_load)
        begin
            tgt_reg      <= spd_next;
            out_acc_reg  <= acc_reg;
            out_gerr_reg <= gerr_reg[24:0];
            out_keep_reg <= keep_reg;
        end
    end

    assign sts.is_release   = op_reg;
    assign target_speed     = tgt_reg;
    assign control_accel    = out_acc_reg;
    assign gap_error        = out_gerr_reg;
    assign keeping_distance = out_keep_reg;

endmodule

/* sv/gkpsc_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gkpsc_ctrl
// Sequencer: steps the datapath through one control item and owns the
// handshakes of both channels.
// ----------------------------------------------------------------------------
module gkpsc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  gkpsc_pkg::dp_sts_t  sts,
    output gkpsc_pkg::dp_cmd_t  ctl
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_DEC    = 4'd1;
    localparam logic [3:0] ST_MGERR  = 4'd2;
    localparam logic [3:0] ST_SETP   = 4'd3;
    localparam logic [3:0] ST_MSETP  = 4'd4;
    localparam logic [3:0] ST_INTEG  = 4'd5;
    localparam logic [3:0] ST_ACC1   = 4'd6;
    localparam logic [3:0] ST_ACC2   = 4'd7;
    localparam logic [3:0] ST_ACC3   = 4'd8;
    localparam logic [3:0] ST_MTS    = 4'd9;
    localparam logic [3:0] ST_OUT    = 4'd10;

    logic [3:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next  = state_reg;
        ctl         = '0;
        in_ready    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = ST_DEC;
                end
            end
            ST_DEC:
            begin
                if (sts.is_release)
                begin
                    ctl.clr_state = 1'b1;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    ctl.upd_sel = gkpsc_pkg::UPD_GERR;
                    state_next  = ST_MGERR;
                end
            end
            ST_MGERR:
            begin
                ctl.mul_sel = gkpsc_pkg::MUL_GERR;
                state_next  = ST_SETP;
            end
            ST_SETP:
            begin
                ctl.upd_sel = gkpsc_pkg::UPD_SETP;
                state_next  = ST_MSETP;
            end
            ST_MSETP:
            begin
                ctl.mul_sel = gkpsc_pkg::MUL_SETP;
                state_next  = ST_INTEG;
            end
            ST_INTEG:
            begin
                ctl.upd_sel = gkpsc_pkg::UPD_INTEG;
                ctl.mul_sel = gkpsc_pkg::MUL_P;
                state_next  = ST_ACC1;
            end
            ST_ACC1:
            begin
                ctl.upd_sel = gkpsc_pkg::UPD_ACC_FIRST;
                ctl.mul_sel = gkpsc_pkg::MUL_I;
                state_next  = ST_ACC2;
            end
            ST_ACC2:
            begin
                ctl.upd_sel = gkpsc_pkg::UPD_ACC_ADD;
                ctl.mul_sel = gkpsc_pkg::MUL_D;
                state_next  = ST_ACC3;
            end
            ST_ACC3:
            begin
                ctl.upd_sel = gkpsc_pkg::UPD_ACC_LAST;
                state_next  = ST_MTS;
            end
            ST_MTS:
            begin
                ctl.mul_sel = gkpsc_pkg::MUL_TS;
                state_next  = ST_OUT;
            end
            ST_OUT:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctl.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

/* sv/gap_keeping_pid_speed_control.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gap_keeping_pid_speed_control
// Gap-keeping cruise controller: gap error, setpoint, PID acceleration and
// clamped commanded speed, sequenced over one shared multiplier.
// ----------------------------------------------------------------------------
//  channel     dir   handshake       word
//  meas        in    valid/ready     opcode, speeds, gap, curve cap
//  actuation   out   valid/ready     target speed, accel, gap error, flag
//  cfg         in    cfg_we          cfg_index, cfg_wdata
//
//  A control word steps through DEC, MGERR, SETP, MSETP, INTEG, ACC1, ACC2,
//  ACC3, MTS and OUT to a loaded result; a release word clears the PID state
//  in DEC. A control word makes six passes through the one 32x32 multiplier.
//  Reset clears the PID state and loads the register defaults at once.
//  A result waiting on actuation does not block the next meas word; the
//  sequencer holds in its last step only while the previous word still waits.
// ----------------------------------------------------------------------------
module gap_keeping_pid_speed_control (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [gkpsc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gkpsc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    gkpsc_meas_if.sink                          meas,
    gkpsc_act_if.source                         actuation
);

    gkpsc_pkg::dp_cmd_t ctl;
    gkpsc_pkg::dp_sts_t sts;

    gkpsc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (meas.valid),
        .in_ready  (meas.ready),
        .out_valid (actuation.valid),
        .out_ready (actuation.ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    gkpsc_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .opcode            (meas.opcode),
        .vehicle_speed     (meas.vehicle_speed),
        .gap_distance      (meas.gap_distance),
        .front_rel_speed   (meas.front_rel_speed),
        .curve_speed_limit (meas.curve_speed_limit),
        .in_curve          (meas.in_curve),
        .ctl               (ctl),
        .sts               (sts),
        .target_speed      (actuation.target_speed),
        .control_accel     (actuation.control_accel),
        .gap_error         (actuation.gap_error),
        .keeping_distance  (actuation.keeping_distance)
    );

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (meas.valid && meas.ready) |=> !meas.ready)
        else $error("meas accepted while a word is in progress");

    a_release_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (meas.valid && meas.ready && meas.opcode) |=> ##1 !$rose(actuation.valid))
        else $error("release word produced a result");

    a_accel_range: assert property (@(posedge clk) disable iff (!rst_n)
        actuation.valid |-> (actuation.control_accel >= gkpsc_pkg::ACCEL_MIN_Q
                             && actuation.control_accel <= gkpsc_pkg::ACCEL_MAX_Q))
        else $error("control_accel outside clamp range");

endmodule
